// ----- hdl/column_select_distinct_filter_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the column select / distinct filter
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef COLUMN_SELECT_DISTINCT_FILTER_MACROS_SVH
`define COLUMN_SELECT_DISTINCT_FILTER_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside of reset.
`define CSDF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true at a rising edge outside of reset.
`define CSDF_NEVER(label, clk, rst, cond, msg) \
   `CSDF_ASSERT(label, clk, rst, !(cond), msg)

`else

`define CSDF_ASSERT(label, clk, rst, prop, msg)
`define CSDF_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ----- hdl/csdf_pkg.sv -----
// ---------------------------------------------------------------------------
// Column select / distinct filter package
// Register indexes, filter modes, result kinds and the result record.
// ---------------------------------------------------------------------------
`default_nettype none

package csdf_pkg;

   // Configuration register indexes.
   localparam logic REG_FILTER_MODE = 1'b0;
   localparam logic REG_MATCH_KEY   = 1'b1;

   typedef enum logic [1:0] {
      MODE_KEY_EQ          = 2'd0,
      MODE_KEY_EQ_DISTINCT = 2'd1,
      MODE_DISTINCT        = 2'd2,
      MODE_AT_LEAST        = 2'd3
   } filter_mode_type;

   localparam logic RESULT_KEPT    = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   localparam int POS_W       = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic             result_kind;
      logic [7:0]       kept_value;
      logic [POS_W-1:0] position;
      logic             final_item;
   } result_type;

endpackage

`default_nettype wire

// ----- hdl/column_select_distinct_filter.sv -----
// ---------------------------------------------------------------------------
// Column select / distinct filter
// Streams one column row by row and emits kept values and a per-column count.
// ---------------------------------------------------------------------------
//
// The block takes one row per clock cycle and filters it in a single pass:
// the row is captured in an input register, the filter decision, seen-map
// lookup and counter update are made on that registered row, and the results
// go into a four-entry result queue that feeds the rsp_ port. A row yields
// at most one kept-value item, and a row with end_of_column set also yields
// a summary item carrying the kept count. Because the result port moves one
// item per cycle, a row that is kept and ends the column puts two items on
// the port; all other rows sustain one item per cycle. The queue is
// what sets the rate: a row is filtered only when the queue has room for
// two items. The 256-entry seen map lives in flip-flops and is cleared in
// the same cycle that filters the last row, so no clearing pass is needed
// and the next column can follow directly. Configuration writes are always
// taken (csr_ready is tied high) and are meant to happen while the block is
// idle.
//
`default_nettype none

`include "column_select_distinct_filter_macros.svh"

module column_select_distinct_filter #(
   parameter longint unsigned MAX_ROWS = 65536
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic signed [7:0]   req_row_value,
   input  wire logic signed [31:0]  req_row_key,
   input  wire logic                req_end_of_column,

   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic                rsp_result_kind,
   output      logic signed [7:0]   rsp_kept_value,
   output      logic [16:0]         rsp_position,
   output      logic                rsp_final_item,

   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic                csr_index,
   input  wire logic [31:0]         csr_data
);

   // The kept counter is wide enough to hold MAX_ROWS itself.
   localparam int CNT_W = $clog2(MAX_ROWS + 1);

   // Configuration registers.
   csdf_pkg::filter_mode_type mode_ff;
   logic signed [31:0]        match_key_ff;

   // Input register.
   logic               in_valid_ff, in_valid_in;
   logic signed [7:0]  in_value_ff;
   logic signed [31:0] in_key_ff;
   logic               in_last_ff;

   // Column state.
   logic [255:0]     seen_ff, seen_in;
   logic [CNT_W-1:0] kept_count_ff, kept_count_in, count_next;

   // Result queue.
   csdf_pkg::result_type              queue_ff [csdf_pkg::QUEUE_DEPTH];
   logic [csdf_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [csdf_pkg::QPTR_W-1:0]       sum_ptr;
   logic [csdf_pkg::QCNT_W-1:0]       q_count_ff, q_count_in;
   logic [1:0]                        push_n;
   logic                              pop;

   logic                 accept;
   logic                 proc_go;
   logic                 key_hit;
   logic                 fresh;
   logic                 at_least;
   logic                 keep;
   logic                 distinct_mode;
   logic [7:0]           value_idx;
   logic signed [31:0]   value_ext;
   logic [CNT_W+15:0]    pos_wide_kept, pos_wide_sum;
   csdf_pkg::result_type kept_res, sum_res, head;

   // ---------------------------------------------------------------------
   // Handshakes. A row is filtered only when the queue can take both of
   // the items it may produce; the input register is refilled in the same
   // cycle, so rows flow at one per cycle.
   // ---------------------------------------------------------------------
   assign proc_go   = in_valid_ff && (q_count_ff <= csdf_pkg::QCNT_W'(csdf_pkg::QUEUE_DEPTH - 2));
   assign req_stall = in_valid_ff && !proc_go;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Filter decision for the registered row.
   // ---------------------------------------------------------------------
   // The seen map is indexed by the raw byte, so negative values map to
   // the upper half of the map.
   assign value_idx = in_value_ff;
   assign value_ext = {{24{in_value_ff[7]}}, in_value_ff};
   assign key_hit   = (in_key_ff == match_key_ff);
   assign fresh     = !seen_ff[value_idx];
   assign at_least  = (value_ext >= match_key_ff);

   always_comb begin
      keep          = 1'b0;
      distinct_mode = 1'b0;
      unique case (mode_ff)
         csdf_pkg::MODE_KEY_EQ: begin
            keep = key_hit;
         end
         csdf_pkg::MODE_KEY_EQ_DISTINCT: begin
            keep          = key_hit && fresh;
            distinct_mode = 1'b1;
         end
         csdf_pkg::MODE_DISTINCT: begin
            keep          = fresh;
            distinct_mode = 1'b1;
         end
         csdf_pkg::MODE_AT_LEAST: begin
            keep = at_least;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // The count saturates at MAX_ROWS; kept values past that point still
   // come out, all at position MAX_ROWS.
   always_comb begin
      count_next = kept_count_ff;
      if (keep && (kept_count_ff < CNT_W'(MAX_ROWS))) begin
         count_next = kept_count_ff + CNT_W'(1);
      end
   end

   // Only the distinct modes mark values in the seen map, and only values they
   // keep. The last row of a column wipes the map and the count at once.
   always_comb begin
      seen_in       = seen_ff;
      kept_count_in = kept_count_ff;
      if (proc_go) begin
         if (keep && distinct_mode) begin
            seen_in[value_idx] = 1'b1;
         end
         kept_count_in = count_next;
         if (in_last_ff) begin
            seen_in       = '0;
            kept_count_in = '0;
         end
      end
   end

   // Positions are the low 17 bits of the count, zero extended when the
   // counter is narrower.
   assign pos_wide_kept = {16'b0, kept_count_ff};
   assign pos_wide_sum  = {16'b0, count_next};

   always_comb begin
      kept_res.result_kind = csdf_pkg::RESULT_KEPT;
      kept_res.kept_value  = in_value_ff;
      kept_res.position    = pos_wide_kept[16:0];
      kept_res.final_item  = 1'b0;

      sum_res.result_kind  = csdf_pkg::RESULT_SUMMARY;
      sum_res.kept_value   = 8'd0;
      sum_res.position     = pos_wide_sum[16:0];
      sum_res.final_item   = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Result queue. The kept item, if any, goes in first and the summary
   // right behind it.
   // ---------------------------------------------------------------------
   assign push_n  = proc_go ? (2'(keep) + 2'(in_last_ff)) : 2'd0;
   assign sum_ptr = wr_ptr_ff + csdf_pkg::QPTR_W'(keep);
   assign pop     = rsp_valid && !rsp_stall;

   assign wr_ptr_in  = wr_ptr_ff + csdf_pkg::QPTR_W'(push_n);
   assign rd_ptr_in  = rd_ptr_ff + csdf_pkg::QPTR_W'(pop);
   assign q_count_in = q_count_ff + csdf_pkg::QCNT_W'(push_n) - csdf_pkg::QCNT_W'(pop);

   assign head            = queue_ff[rd_ptr_ff];
   assign rsp_valid       = (q_count_ff != '0);
   assign rsp_result_kind = head.result_kind;
   assign rsp_kept_value  = head.kept_value;
   assign rsp_position    = head.position;
   assign rsp_final_item  = head.final_item;

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= csdf_pkg::MODE_KEY_EQ;
         match_key_ff  <= '0;
         in_valid_ff   <= 1'b0;
         seen_ff       <= '0;
         kept_count_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         q_count_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               csdf_pkg::REG_FILTER_MODE: begin
                  mode_ff <= csdf_pkg::filter_mode_type'(csr_data[1:0]);
               end
               csdf_pkg::REG_MATCH_KEY: begin
                  match_key_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
         in_valid_ff   <= in_valid_in;
         seen_ff       <= seen_in;
         kept_count_ff <= kept_count_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         q_count_ff    <= q_count_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_value_ff <= req_row_value;
         in_key_ff   <= req_row_key;
         in_last_ff  <= req_end_of_column;
      end
      if (proc_go && keep) begin
         queue_ff[wr_ptr_ff] <= kept_res;
      end
      if (proc_go && in_last_ff) begin
         queue_ff[sum_ptr] <= sum_res;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `CSDF_NEVER(a_queue_overflow, clock, reset,
               q_count_ff > csdf_pkg::QCNT_W'(csdf_pkg::QUEUE_DEPTH),
               "result queue holds more items than it has entries")
   `CSDF_NEVER(a_count_saturates, clock, reset, kept_count_ff > CNT_W'(MAX_ROWS),
               "kept count ran past MAX_ROWS")
   `CSDF_ASSERT(a_column_end_clears, clock, reset,
                proc_go && in_last_ff |=> kept_count_ff == '0 && seen_ff == '0,
                "column state not cleared after the last row")
   `CSDF_ASSERT(a_summary_is_final, clock, reset,
                rsp_valid |-> (rsp_final_item == rsp_result_kind),
                "final mark does not match the summary item")

endmodule

`default_nettype wire
